// ===== hw/rtl/telemetry_frame_encoder_crc8_assert.svh =====
// assertion macros for the telemetry frame encoder
// expects clk and rst_n in the scope where a macro is used
`ifndef TELEMETRY_FRAME_ENCODER_CRC8_ASSERT_SVH
`define TELEMETRY_FRAME_ENCODER_CRC8_ASSERT_SVH

// same-cycle implication
`define TFE_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define TFE_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/tfe_pkg.sv =====
// shared types, constants and the crc step for the telemetry frame encoder
// no dependencies
package tfe_pkg;

    // record kinds
    localparam logic [1:0] CMD_GPS  = 2'd0;
    localparam logic [1:0] CMD_BATT = 2'd1;
    localparam logic [1:0] CMD_ATT  = 2'd2;
    localparam logic [1:0] CMD_LINK = 2'd3;

    // configuration register indexes
    localparam int unsigned       CFG_IDX_W    = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK  = 3'd4;

    // register reset values
    localparam logic [7:0] RST_ADDR = 8'd234;
    localparam logic [7:0] RST_GPS  = 8'd2;
    localparam logic [7:0] RST_BATT = 8'd8;
    localparam logic [7:0] RST_ATT  = 8'd30;
    localparam logic [7:0] RST_LINK = 8'd20;

    // length bytes: type + payload + crc
    localparam logic [7:0] LEN_GPS  = 8'd17;
    localparam logic [7:0] LEN_BATT = 8'd10;
    localparam logic [7:0] LEN_ATT  = 8'd8;
    localparam logic [7:0] LEN_LINK = 8'd12;

    // crc polynomial
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // scale factors: battery x100, attitude 10000*pi/360 in q.24
    localparam logic [7:0]  BATT_FACTOR = 8'd100;
    localparam logic [31:0] ATT_FACTOR  = 32'd1464088293;

    // type byte plus the longest payload
    localparam int unsigned BODY_BYTES = 16;
    localparam int unsigned BODY_W     = BODY_BYTES * 8;

    // frame handed to the serializer
    typedef struct packed {
        logic [7:0]        addr;
        logic [7:0]        len;
        logic [BODY_W-1:0] body;
    } tfe_frame_t;

    // scaler request
    typedef struct packed {
        logic start;
        logic is_att;
    } tfe_scl_ctl_t;

    // scaler result
    typedef struct packed {
        logic        done;
        logic [15:0] value;
    } tfe_scl_sts_t;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/tfe_rec_if.sv =====
// telemetry record channel: valid, ready and the record fields
// no dependencies
interface tfe_rec_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] wide_a;
    logic signed [31:0] wide_b;
    logic signed [31:0] wide_c;
    logic [15:0]        half_a;
    logic [15:0]        half_b;
    logic [15:0]        half_c;
    logic [7:0]         small_a;

    modport source (
        output valid, cmd, wide_a, wide_b, wide_c, half_a, half_b, half_c, small_a,
        input  ready
    );
    modport sink (
        input  valid, cmd, wide_a, wide_b, wide_c, half_a, half_b, half_c, small_a,
        output ready
    );
endinterface

// ===== hw/rtl/tfe_byte_if.sv =====
// frame byte channel: valid, ready, byte and end-of-frame mark
// no dependencies
interface tfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== hw/rtl/tfe_scaler.sv =====
// digit-serial fixed-point scaler: signed raw times a constant, one byte of
// the constant per cycle, then round to nearest even; depends on tfe_pkg
module tfe_scaler (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tfe_pkg::tfe_scl_ctl_t ctl,
    input  logic signed [31:0]   raw,
    output tfe_pkg::tfe_scl_sts_t sts
);
    import tfe_pkg::*;

    logic               busy_reg, busy_next;
    logic               rnd_reg, rnd_next;
    logic               done_reg, done_next;
    logic [1:0]         k_reg, k_next;
    logic               att_reg, att_next;
    logic signed [31:0] raw_reg, raw_next;
    logic [63:0]        acc_reg, acc_next;
    logic [15:0]        res_reg, res_next;

    logic [7:0]         digit;
    logic signed [8:0]  digit_s;
    logic signed [40:0] partial;
    logic [63:0]        partial_x;
    logic [63:0]        partial_sh;
    logic [1:0]         k_last;
    logic [7:0]         b_rem;
    logic [31:0]        a_rem;
    logic               b_inc, a_inc, b_sat, b_nonpos;
    logic [16:0]        b_sum;
    logic [15:0]        b_val, a_val;

    // current digit of the constant
    always_comb
    begin
        digit      = att_reg ? ATT_FACTOR[{k_reg, 3'b000} +: 8] : BATT_FACTOR;
        digit_s    = $signed({1'b0, digit});
        partial    = raw_reg * digit_s;
        partial_x  = {{23{partial[40]}}, partial};
        partial_sh = partial_x << {k_reg, 3'b000};
        k_last     = att_reg ? 2'd3 : 2'd0;
    end

    // battery: q.8 product, round, clamp to 0..65535
    always_comb
    begin
        b_rem    = acc_reg[7:0];
        b_inc    = (b_rem > 8'd128) || ((b_rem == 8'd128) && acc_reg[8]);
        b_sum    = {1'b0, acc_reg[23:8]} + {16'd0, b_inc};
        b_nonpos = acc_reg[63] || (acc_reg == 64'd0);
        b_sat    = (acc_reg[62:24] != 39'd0) || b_sum[16];
        if (b_nonpos)
            b_val = 16'd0;
        else if (b_sat)
            b_val = 16'hFFFF;
        else
            b_val = b_sum[15:0];
    end

    // attitude: q.32 product, round, wrap to 16 bits
    always_comb
    begin
        a_rem = acc_reg[31:0];
        a_inc = (a_rem > 32'h8000_0000) || ((a_rem == 32'h8000_0000) && acc_reg[32]);
        a_val = acc_reg[47:32] + {15'd0, a_inc};
    end

    // sequencing: load, accumulate digits, round
    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        att_next  = att_reg;
        raw_next  = raw_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        if (!busy_reg)
        begin
            if (ctl.start)
            begin
                busy_next = 1'b1;
                rnd_next  = 1'b0;
                k_next    = 2'd0;
                att_next  = ctl.is_att;
                raw_next  = raw;
                acc_next  = 64'd0;
            end
        end
        else if (rnd_reg)
        begin
            res_next  = att_reg ? a_val : b_val;
            done_next = 1'b1;
            busy_next = 1'b0;
            rnd_next  = 1'b0;
        end
        else
        begin
            acc_next = acc_reg + partial_sh;
            if (k_reg == k_last)
                rnd_next = 1'b1;
            else
                k_next = k_reg + 2'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        att_reg <= att_next;
        raw_reg <= raw_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign sts.done  = done_reg;
    assign sts.value = res_reg;

endmodule

// ===== hw/rtl/tfe_serializer.sv =====
// byte serializer: shifts out one frame byte per cycle while frame is ready,
// through an output register, and appends the running crc-8; depends on tfe_pkg, tfe_byte_if
module tfe_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tfe_pkg::tfe_frame_t desc,
    output logic                idle,
    tfe_byte_if.source          frame
);
    import tfe_pkg::*;

    localparam int unsigned SH_W = BODY_W + 16;

    logic            busy_reg, busy_next;
    logic            valid_reg, valid_next;
    logic [SH_W-1:0] sh_reg, sh_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [4:0]      nbytes_reg, nbytes_next;
    logic [7:0]      crc_reg, crc_next;
    logic [7:0]      byte_reg, byte_next;
    logic            last_reg, last_next;
    logic            adv;
    logic [7:0]      head;

    assign head = sh_reg[SH_W-1 -: 8];
    assign adv  = busy_reg && (!valid_reg || frame.ready);

    // next byte into the output register
    always_comb
    begin
        busy_next   = busy_reg;
        valid_next  = valid_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        nbytes_next = nbytes_reg;
        crc_next    = crc_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        if (load)
        begin
            busy_next   = 1'b1;
            sh_next     = {desc.addr, desc.len, desc.body};
            cnt_next    = 5'd0;
            nbytes_next = desc.len[4:0] + 5'd1;
            crc_next    = 8'd0;
        end
        else
        begin
            if (valid_reg && frame.ready)
                valid_next = 1'b0;
            if (adv)
            begin
                valid_next = 1'b1;
                if (cnt_reg == nbytes_reg)
                begin
                    byte_next = crc_reg;
                    last_next = 1'b1;
                    busy_next = 1'b0;
                end
                else
                begin
                    byte_next = head;
                    last_next = 1'b0;
                    sh_next   = {sh_reg[SH_W-9:0], 8'd0};
                    cnt_next  = cnt_reg + 5'd1;
                    // address and length stay out of the crc
                    if (cnt_reg >= 5'd2)
                        crc_next = crc8_byte(crc_reg, head);
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        sh_reg     <= sh_next;
        cnt_reg    <= cnt_next;
        nbytes_reg <= nbytes_next;
        crc_reg    <= crc_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
    end

    assign idle             = !busy_reg && !valid_reg;
    assign frame.valid      = valid_reg;
    assign frame.frame_byte = byte_reg;
    assign frame.last_byte  = last_reg;

endmodule

// ===== hw/rtl/telemetry_frame_encoder_crc8.sv =====
// telemetry frame encoder with crc-8, top level
// depends on tfe_pkg, tfe_rec_if, tfe_byte_if, tfe_scaler, tfe_serializer
//
// Usage: one telemetry record is taken on telem (valid/ready) and turned into
// one byte frame on frame (valid/ready): address, length, type, big-endian
// payload and a crc-8 (poly 0xD5, init 0) over type and payload; last_byte
// marks the crc byte. Registers are written through cfg_wr_en/cfg_index/
// cfg_wdata, by the user only while the block is idle (the block itself
// leaves this unchecked); indexes past the list are ignored.
// One record at a time: telem.ready is high only between frames.
// Battery and attitude records take one scaling pass per value on the
// shared digit-serial multiplier, which takes one byte of the constant
// per cycle; gps and link records go straight to the load state. The
// serializer sends one byte per cycle while frame is ready.
// A stall on frame holds the output register and the serializer; nothing is
// lost. Reset clears all control state and loads the register defaults.
module telemetry_frame_encoder_crc8 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_wdata,
    tfe_rec_if.sink                        telem,
    tfe_byte_if.source                     frame
);
    import tfe_pkg::*;

    `include "telemetry_frame_encoder_crc8_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_SEND  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  addr_reg, gps_reg, batt_reg, att_reg, link_reg;

    logic [1:0]         cmd_reg;
    logic signed [31:0] wa_reg, wb_reg, wc_reg;
    logic [15:0]        ha_reg, hb_reg, hc_reg;
    logic [7:0]         sa_reg;
    logic [15:0]        v0_reg, v1_reg, v2_reg;

    logic               accept;
    logic               ser_idle;
    logic               ser_load;
    tfe_frame_t         desc;
    tfe_scl_ctl_t       scl_ctl;
    tfe_scl_sts_t       scl_sts;
    logic signed [31:0] scl_raw;
    logic [1:0]         idx_last;

    assign telem.ready = (state_reg == S_IDLE);
    assign accept      = telem.valid && telem.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= RST_ADDR;
            gps_reg  <= RST_GPS;
            batt_reg <= RST_BATT;
            att_reg  <= RST_ATT;
            link_reg <= RST_LINK;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ADDR: addr_reg <= cfg_wdata;
                CFG_GPS:  gps_reg  <= cfg_wdata;
                CFG_BATT: batt_reg <= cfg_wdata;
                CFG_ATT:  att_reg  <= cfg_wdata;
                CFG_LINK: link_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // record capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= telem.cmd;
            wa_reg  <= telem.wide_a;
            wb_reg  <= telem.wide_b;
            wc_reg  <= telem.wide_c;
            ha_reg  <= telem.half_a;
            hb_reg  <= telem.half_b;
            hc_reg  <= telem.half_c;
            sa_reg  <= telem.small_a;
        end
    end

    // scaled values land by index
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WAIT && scl_sts.done)
        begin
            unique case (idx_reg)
                2'd0:    v0_reg <= scl_sts.value;
                2'd1:    v1_reg <= scl_sts.value;
                default: v2_reg <= scl_sts.value;
            endcase
        end
    end

    // scaler request
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    scl_raw = wa_reg;
            2'd1:    scl_raw = wb_reg;
            default: scl_raw = wc_reg;
        endcase
        scl_ctl.start  = (state_reg == S_START);
        scl_ctl.is_att = (cmd_reg == CMD_ATT);
        idx_last       = (cmd_reg == CMD_ATT) ? 2'd2 : 2'd1;
    end

    // frame layout per record kind
    always_comb
    begin
        desc.addr = addr_reg;
        unique case (cmd_reg)
            CMD_GPS:
            begin
                desc.len  = LEN_GPS;
                desc.body = {gps_reg, wa_reg, wb_reg, ha_reg, hb_reg, hc_reg, sa_reg};
            end
            CMD_BATT:
            begin
                desc.len  = LEN_BATT;
                desc.body = {batt_reg, v0_reg, v1_reg, wc_reg[23:0], sa_reg, 56'd0};
            end
            CMD_ATT:
            begin
                desc.len  = LEN_ATT;
                desc.body = {att_reg, v0_reg, v1_reg, v2_reg, 72'd0};
            end
            default:
            begin
                desc.len  = LEN_LINK;
                desc.body = {link_reg, wa_reg, wb_reg, ha_reg, 40'd0};
            end
        endcase
    end

    assign ser_load = (state_reg == S_LOAD);

    // record sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = 2'd0;
                    if (telem.cmd == CMD_BATT || telem.cmd == CMD_ATT)
                        state_next = S_START;
                    else
                        state_next = S_LOAD;
                end
            end
            S_START:
                state_next = S_WAIT;
            S_WAIT:
            begin
                if (scl_sts.done)
                begin
                    if (idx_reg == idx_last)
                        state_next = S_LOAD;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_START;
                    end
                end
            end
            S_LOAD:
                state_next = S_SEND;
            S_SEND:
            begin
                if (ser_idle)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    tfe_scaler u_scaler (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scl_ctl),
        .raw   (scl_raw),
        .sts   (scl_sts)
    );

    tfe_serializer u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (ser_load),
        .desc  (desc),
        .idle  (ser_idle),
        .frame (frame)
    );

    // checks
    `TFE_ASSERT_IMP(a_ready_only_when_drained, telem.ready, ser_idle, "record taken mid-frame")
    `TFE_ASSERT_IMP(a_scale_done_in_wait, scl_sts.done, state_reg == S_WAIT, "stray scaler result")
    `TFE_ASSERT_IMP(a_bytes_only_in_send, frame.valid, state_reg == S_SEND, "byte outside send")
    `TFE_ASSERT_NXT(a_load_starts_send, ser_load, !ser_idle, "serializer did not start on load")

endmodule

// ===== sim/telemetry_frame_encoder_crc8_test.sv =====
// testbench for the telemetry frame encoder: drives records, checks every frame byte
// depends on tfe_pkg, tfe_rec_if, tfe_byte_if and telemetry_frame_encoder_crc8
module telemetry_frame_encoder_crc8_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfe_pkg::*;

    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES    = 40;
    localparam int unsigned RANDOM_PHASES    = 4;
    localparam int unsigned PHASE_RECORDS    = 39;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] wide_a;
        logic signed [31:0] wide_b;
        logic signed [31:0] wide_c;
        logic [15:0]        half_a;
        logic [15:0]        half_b;
        logic [15:0]        half_c;
        logic [7:0]         small_a;
    } telem_rec_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_octet_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_RHYTHM, RX_SPARSE} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic hold_long;
    event long_hold_ev;

    tfe_rec_if  telem_ch ();
    tfe_byte_if frame_ch ();

    // register mirror
    logic [7:0] addr_code;
    logic [7:0] type_code [4];

    // frame bytes still owed by the block, oldest first
    frame_octet_t pending_bytes [$];

    int unsigned mismatches;
    int unsigned records_sent;
    int unsigned frames_seen;
    int unsigned bytes_seen;
    int unsigned settings_used;
    int unsigned burst_left;

    telemetry_frame_encoder_crc8 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .telem     (telem_ch),
        .frame     (frame_ch)
    );

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // ---------------------------------------------------------------------
    // frame prediction
    // ---------------------------------------------------------------------

    function automatic logic [7:0] crc_d5_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        repeat (8)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // volts or amps in q.8 times 100, round half even, clamp to 16 bits
    function automatic logic [15:0] scale_battery(input logic signed [31:0] raw);
        logic signed [63:0] prod;
        logic [63:0] quo;
        prod = raw;
        prod = prod * 64'sd100;
        if (prod <= 0)
            return 16'd0;
        quo = prod >> 8;
        if (prod[7:0] > 8'd128 || (prod[7:0] == 8'd128 && quo[0]))
            quo = quo + 64'd1;
        if (quo > 64'd65535)
            return 16'hFFFF;
        return quo[15:0];
    endfunction

    // degrees in q.8 times the q.24 factor gives q.32, round half even, keep 16 bits
    function automatic logic [15:0] scale_angle(input logic signed [31:0] raw);
        logic signed [63:0] prod;
        logic signed [63:0] factor;
        logic [63:0] quo;
        factor = {32'd0, ATT_FACTOR};
        prod = raw;
        prod = prod * factor;
        quo = prod >> 32;
        if (prod[31:0] > 32'h8000_0000 || (prod[31:0] == 32'h8000_0000 && quo[0]))
            quo = quo + 64'd1;
        return quo[15:0];
    endfunction

    function automatic void append_be(ref logic [7:0] body[$], input logic [31:0] v,
                                      input int n);
        for (int i = n - 1; i >= 0; i--)
            body.insert(body.size(), v[8*i +: 8]);
    endfunction

    // add one owed byte at the tail
    function automatic void owe_octet(input logic [7:0] data, input logic last);
        frame_octet_t o;
        o.data = data;
        o.last = last;
        pending_bytes.insert(pending_bytes.size(), o);
    endfunction

    // queue the whole frame that one record must produce
    function automatic void encode_frame(input telem_rec_t r);
        logic [7:0] body [$];
        logic [7:0] len;
        logic [7:0] crc;
        body.insert(body.size(), type_code[r.cmd]);
        case (r.cmd)
            CMD_GPS:
            begin
                len = LEN_GPS;
                append_be(body, r.wide_a, 4);
                append_be(body, r.wide_b, 4);
                append_be(body, {16'd0, r.half_a}, 2);
                append_be(body, {16'd0, r.half_b}, 2);
                append_be(body, {16'd0, r.half_c}, 2);
                append_be(body, {24'd0, r.small_a}, 1);
            end
            CMD_BATT:
            begin
                len = LEN_BATT;
                append_be(body, {16'd0, scale_battery(r.wide_a)}, 2);
                append_be(body, {16'd0, scale_battery(r.wide_b)}, 2);
                append_be(body, r.wide_c, 3);
                append_be(body, {24'd0, r.small_a}, 1);
            end
            CMD_ATT:
            begin
                len = LEN_ATT;
                append_be(body, {16'd0, scale_angle(r.wide_a)}, 2);
                append_be(body, {16'd0, scale_angle(r.wide_b)}, 2);
                append_be(body, {16'd0, scale_angle(r.wide_c)}, 2);
            end
            default:
            begin
                len = LEN_LINK;
                append_be(body, r.wide_a, 4);
                append_be(body, r.wide_b, 4);
                append_be(body, {16'd0, r.half_a}, 2);
            end
        endcase
        crc = 8'd0;
        foreach (body[i])
            crc = crc_d5_update(crc, body[i]);
        owe_octet(addr_code, 1'b0);
        owe_octet(len, 1'b0);
        foreach (body[i])
            owe_octet(body[i], 1'b0);
        owe_octet(crc, 1'b1);
    endfunction

    // ---------------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------------

    // compare every accepted frame byte with the oldest one owed
    always @(posedge clk)
    begin
        frame_octet_t want;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("byte %02h with no frame pending",
                                          frame_ch.frame_byte));
            else
            begin
                want = pending_bytes.pop_front();
                if (frame_ch.frame_byte !== want.data)
                    report_mismatch($sformatf("frame %0d: byte %02h, want %02h",
                                              frames_seen, frame_ch.frame_byte, want.data));
                if (frame_ch.last_byte !== want.last)
                    report_mismatch($sformatf("frame %0d: last_byte %b, want %b",
                                              frames_seen, frame_ch.last_byte, want.last));
            end
            bytes_seen++;
            if (frame_ch.last_byte === 1'b1)
                frames_seen++;
        end
    end

    // receiver: stall pattern that switches to a random mode after each random stretch
    initial
    begin
        rx_mode_t mode;
        int unsigned left;
        int unsigned beat;
        frame_ch.ready <= 1'b0;
        mode = RX_OPEN;
        left = 0;
        beat = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 120);
            end
            left--;
            beat++;
            case (mode)
                RX_OPEN:   frame_ch.ready <= !hold_long;
                RX_COIN:   frame_ch.ready <= !hold_long && ($urandom_range(0, 1) == 1);
                RX_RHYTHM: frame_ch.ready <= !hold_long && (beat % 4 != 3);
                default:   frame_ch.ready <= !hold_long && ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        hold_long <= 1'b0;
        forever
        begin
            @(long_hold_ev);
            hold_long <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            hold_long <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    function automatic telem_rec_t make_rec(input logic [1:0] cmd,
                                            input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [15:0] ha,
                                            input logic [15:0] hb, input logic [15:0] hc,
                                            input logic [7:0] sa);
        telem_rec_t r;
        r.cmd = cmd;
        r.wide_a = a;
        r.wide_b = b;
        r.wide_c = c;
        r.half_a = ha;
        r.half_b = hb;
        r.half_c = hc;
        r.small_a = sa;
        return r;
    endfunction

    // full-range values, some extremes, some in the useful range of the kind
    function automatic logic [31:0] pick_wide(input logic [1:0] cmd);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'd0;
            4, 5, 6:
            begin
                if (cmd == CMD_BATT)
                    v = $urandom_range(0, 180000) - 1000;
                else if (cmd == CMD_ATT)
                    v = $urandom_range(0, 184320) - 92160;
                else
                    v = $urandom;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic telem_rec_t random_record();
        telem_rec_t r;
        r.cmd = 2'($urandom_range(0, 3));
        r.wide_a = pick_wide(r.cmd);
        r.wide_b = pick_wide(r.cmd);
        r.wide_c = pick_wide(r.cmd);
        r.half_a = 16'($urandom);
        r.half_b = 16'($urandom);
        r.half_c = 16'($urandom);
        r.small_a = 8'($urandom);
        return r;
    endfunction

    // sender gaps: random bursts, random idle stretches in between
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                telem_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // offer one record, wait for the transaction, predict its frame
    task automatic send_record(input telem_rec_t r, input bit paced);
        telem_ch.valid   <= 1'b1;
        telem_ch.cmd     <= r.cmd;
        telem_ch.wide_a  <= r.wide_a;
        telem_ch.wide_b  <= r.wide_b;
        telem_ch.wide_c  <= r.wide_c;
        telem_ch.half_a  <= r.half_a;
        telem_ch.half_b  <= r.half_b;
        telem_ch.half_c  <= r.half_c;
        telem_ch.small_a <= r.small_a;
        do
            @(posedge clk);
        while (telem_ch.ready !== 1'b1);
        encode_frame(r);
        records_sent++;
        if (paced)
            pace_sender();
    endtask

    // drop valid and wait until every owed byte has come out
    task automatic drain_frames();
        telem_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers plus one index past the list; block must be idle
    task automatic load_settings(input logic [7:0] addr, input logic [7:0] gps,
                                 input logic [7:0] batt, input logic [7:0] att,
                                 input logic [7:0] link);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [7:0] val [6];
        idx = '{CFG_ADDR, CFG_GPS, CFG_BATT, CFG_ATT, CFG_LINK, CFG_SPARE};
        val = '{addr, gps, batt, att, link, ~addr};
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        addr_code = addr;
        type_code[CMD_GPS] = gps;
        type_code[CMD_BATT] = batt;
        type_code[CMD_ATT] = att;
        type_code[CMD_LINK] = link;
        settings_used++;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    task automatic test_gps_fields();
        send_record(make_rec(CMD_GPS, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 8'd0), 1);
        send_record(make_rec(CMD_GPS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1);
        send_record(make_rec(CMD_GPS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_5A5A,
                             16'h8001, 16'h7FFE, 16'h00FF, 8'h80), 1);
        drain_frames();
    endtask

    // ties to even and odd, below one half, negative, saturation, capacity high bits
    task automatic test_battery_scaling();
        send_record(make_rec(CMD_BATT, 32'd32, 32'd96, 32'hFFFF_FFFF,
                             16'h1234, 16'h5678, 16'h9ABC, 8'd0), 1);
        send_record(make_rec(CMD_BATT, 32'd1, -32'sd256, 32'h1234_5678,
                             16'd0, 16'd0, 16'd0, 8'd255), 1);
        send_record(make_rec(CMD_BATT, 32'd167770, 32'd167771, 32'd0,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd100), 1);
        send_record(make_rec(CMD_BATT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF,
                             16'd0, 16'd0, 16'd0, 8'd1), 1);
        drain_frames();
    endtask

    // zero, smallest steps, extremes (the most negative one is an exact tie), wraps
    task automatic test_attitude_scaling();
        send_record(make_rec(CMD_ATT, 32'd0, 32'd1, 32'hFFFF_FFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1);
        send_record(make_rec(CMD_ATT, 32'h7FFF_FFFF, 32'h8000_0000, 32'd92160,
                             16'd0, 16'd0, 16'd0, 8'd0), 1);
        send_record(make_rec(CMD_ATT, -32'sd46080, 32'd23040, 32'd2,
                             16'h0F0F, 16'hF0F0, 16'h3C3C, 8'h3C), 1);
        drain_frames();
    endtask

    task automatic test_link_packing();
        send_record(make_rec(CMD_LINK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1);
        send_record(make_rec(CMD_LINK, 32'h0102_0304, 32'hA0B0_C0D0, 32'd0,
                             16'hBEEF, 16'd0, 16'd0, 8'd0), 1);
        drain_frames();
    endtask

    // all-zero and all-one register values, one frame of each kind under each
    task automatic test_register_extremes();
        telem_rec_t r;
        load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        for (int k = 0; k < 4; k++)
        begin
            r = random_record();
            r.cmd = 2'(k);
            send_record(r, 1);
        end
        drain_frames();
        load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        for (int k = 0; k < 4; k++)
        begin
            r = random_record();
            r.cmd = 2'(3 - k);
            send_record(r, 1);
        end
        drain_frames();
        load_settings(RST_ADDR, RST_GPS, RST_BATT, RST_ATT, RST_LINK);
    endtask

    // receiver holds off for a long stretch while records keep coming
    task automatic test_output_backpressure();
        -> long_hold_ev;
        repeat (6)
            send_record(random_record(), 0);
        drain_frames();
    endtask

    // phases of random records, fresh register values between phases
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
                load_settings(RST_ADDR, RST_GPS, RST_BATT, RST_ATT, RST_LINK);
            else if (p > 0)
                load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
            for (int n = 0; n < PHASE_RECORDS; n++)
                send_record(random_record(), 1);
            drain_frames();
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_ADDR;
        cfg_wdata <= 8'd0;
        telem_ch.valid <= 1'b0;
        telem_ch.cmd <= CMD_GPS;
        telem_ch.wide_a <= '0;
        telem_ch.wide_b <= '0;
        telem_ch.wide_c <= '0;
        telem_ch.half_a <= '0;
        telem_ch.half_b <= '0;
        telem_ch.half_c <= '0;
        telem_ch.small_a <= '0;
        addr_code = RST_ADDR;
        type_code[CMD_GPS] = RST_GPS;
        type_code[CMD_BATT] = RST_BATT;
        type_code[CMD_ATT] = RST_ATT;
        type_code[CMD_LINK] = RST_LINK;
        mismatches = 0;
        records_sent = 0;
        frames_seen = 0;
        bytes_seen = 0;
        settings_used = 1;
        burst_left = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gps_fields();
        test_battery_scaling();
        test_attitude_scaling();
        test_link_packing();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();

        $display("covered %0d records of all four kinds under %0d register settings,",
                 records_sent, settings_used);
        $display("%0d frames and %0d frame bytes checked, %0d mismatches",
                 frames_seen, bytes_seen, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
